@@ rtl/dms_pkg.sv @@
// dms_pkg: shared types, codes and constants of the device mode supervisor.
// Used by every file under rtl/; depends on nothing.

package dms_pkg;

    localparam int unsigned SEC_W    = 23;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned MSLIM_W  = 33;
    localparam int unsigned MV_W     = 16;
    localparam int unsigned CNT_W    = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [TIME_W-1:0] MS_PER_S = 32'd1000;

    localparam logic [TIME_W-1:0] NO_NET_TIMEOUT_MS_DEF = 32'd120000;
    localparam logic [TIME_W-1:0] NO_NET_SLEEP_S_DEF    = 32'd3600;

    // request types
    localparam logic [2:0] REQ_POLL     = 3'd0;
    localparam logic [2:0] REQ_ACTIVITY = 3'd1;
    localparam logic [2:0] REQ_LINK_DN  = 3'd2;
    localparam logic [2:0] REQ_LINK_UP  = 3'd3;
    localparam logic [2:0] REQ_AGG_PUB  = 3'd4;
    localparam logic [2:0] REQ_COMMAND  = 3'd5;

    // server commands
    localparam logic [3:0] CMD_NUDGE     = 4'd0;
    localparam logic [3:0] CMD_KEEP      = 4'd1;
    localparam logic [3:0] CMD_START     = 4'd2;
    localparam logic [3:0] CMD_STOP      = 4'd3;
    localparam logic [3:0] CMD_GETCONFIG = 4'd4;
    localparam logic [3:0] CMD_HIBERNATE = 4'd5;
    localparam logic [3:0] CMD_BATRESET  = 4'd6;
    localparam logic [3:0] CMD_FACTORY   = 4'd7;

    // modes
    localparam logic [1:0] MODE_AWARE       = 2'd0;
    localparam logic [1:0] MODE_SAMPLING    = 2'd1;
    localparam logic [1:0] MODE_HIBERNATING = 2'd2;

    // sleep reasons
    localparam logic [1:0] RSN_INACTIVITY = 2'd0;
    localparam logic [1:0] RSN_FORCED     = 2'd1;
    localparam logic [1:0] RSN_EMERGENCY  = 2'd2;
    localparam logic [1:0] RSN_NO_NET     = 2'd3;

    // side requests
    localparam logic [2:0] SIDE_NONE     = 3'd0;
    localparam logic [2:0] SIDE_SESSION  = 3'd1;
    localparam logic [2:0] SIDE_PUB_CFG  = 3'd2;
    localparam logic [2:0] SIDE_BAT_RST  = 3'd3;
    localparam logic [2:0] SIDE_FACTORY  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AWARE_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STATUS_IVL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_UNACKED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_SLEEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FORCED    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BATT      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_EMERG_DELAY   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_EMERG_SLEEP   = 3'd7;

    // register reset values
    localparam logic [SEC_W-1:0]  RST_AWARE_TIMEOUT_S = 23'd300;
    localparam logic [SEC_W-1:0]  RST_STATUS_IVL_S    = 23'd60;
    localparam logic [CNT_W-1:0]  RST_MAX_UNACKED     = 16'd3;
    localparam logic [TIME_W-1:0] RST_DEFAULT_SLEEP_S = 32'd3600;
    localparam logic [TIME_W-1:0] RST_MAX_FORCED_S    = 32'd86400;
    localparam logic [MV_W-1:0]   RST_LOW_BATT_MV     = 16'd3300;
    localparam logic [SEC_W-1:0]  RST_EMERG_DELAY_S   = 23'd60;
    localparam logic [TIME_W-1:0] RST_EMERG_SLEEP_S   = 32'd7200;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [TIME_W-1:0] now_ms;
        logic [3:0]        cmd_code;
        logic [TIME_W-1:0] cmd_sleep_s;
        logic [MV_W-1:0]   battery_mv;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic              mode_entered;
        logic [1:0]        prior_mode;
        logic              status_report;
        logic              low_battery_alert;
        logic              sleep_request;
        logic [TIME_W-1:0] sleep_seconds;
        logic [1:0]        sleep_reason;
        logic [2:0]        side_request;
    } out_beat_t;

    // Configuration as the core sees it: timer second counts already scaled to ms, sleep times in s.
    typedef struct packed {
        logic [MSLIM_W-1:0] aware_timeout_ms;
        logic [MSLIM_W-1:0] status_ivl_ms;
        logic [TIME_W-1:0]  emerg_delay_ms;   // wrapped, only added to now
        logic [CNT_W-1:0]   unacked_limit;    // zero already mapped to one
        logic [TIME_W-1:0]  idle_sleep_s;
        logic [TIME_W-1:0]  max_forced_s;
        logic [MV_W-1:0]    low_batt_mv;
        logic [TIME_W-1:0]  emerg_sleep_s;
    } cfg_t;

    function automatic logic [MSLIM_W-1:0] ms_of(input logic [SEC_W-1:0] s);
        ms_of = {{(MSLIM_W-SEC_W){1'b0}}, s} * MSLIM_W'(MS_PER_S);
    endfunction

endpackage

@@ rtl/device_mode_supervisor_top.sv @@
// device_mode_supervisor_top: top level of the device mode supervisor.
// Depends on dms_pkg, dms_cfg and dms_core.
//
// Usage:
//  - Input channel s_valid/s_ready/s_data carries one request beat: a poll
//    with battery sample, an activity/link/aggregate event or a decoded
//    server command, each stamped with now_ms since boot.
//  - Result channel m_valid/m_ready/m_data returns exactly one beat per
//    request: mode, entry flags, status/alert flags, sleep request and a
//    side request.
//  - Config port cfg_wr_en/cfg_addr/cfg_wdata writes one register per cycle,
//    no wait states; write only while no request is in flight.
//  - Result path: an accepted beat is held in the input register, then the
//    update logic forms its result into the result register that drives m_data.
//  - Throughput: one beat per cycle while m_ready holds; the mode state is
//    updated in the single pass that forms the result, so beats chain directly.
//  - Receiver stall: the result register holds its beat; the input register
//    takes one more beat, then s_ready drops until m_ready returns.
//  - Reset (aresetn low, synchronous): both channels empty, mode aware,
//    timers, counters and flags cleared, registers at their defaults.

module device_mode_supervisor_top #(
    parameter logic [dms_pkg::TIME_W-1:0] NO_NET_TIMEOUT_MS = dms_pkg::NO_NET_TIMEOUT_MS_DEF,
    parameter logic [dms_pkg::TIME_W-1:0] NO_NET_SLEEP_S    = dms_pkg::NO_NET_SLEEP_S_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [dms_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [dms_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  dms_pkg::in_beat_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output dms_pkg::out_beat_t             m_data
);

    // Second-valued timer registers are kept pre-scaled to ms; sleep times stay in s.
    dms_pkg::cfg_t cfg;

    dms_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Request pipeline and supervisor state.
    dms_core #(
        .NO_NET_TIMEOUT_MS (NO_NET_TIMEOUT_MS),
        .NO_NET_SLEEP_S    (NO_NET_SLEEP_S)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

@@ rtl/dms_cfg.sv @@
// dms_cfg: configuration registers, timer values scaled to milliseconds at write time.
// Depends on dms_pkg.

module dms_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [dms_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [dms_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output dms_pkg::cfg_t                     cfg
);

    dms_pkg::cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                dms_pkg::CFG_AWARE_TIMEOUT: begin
                    cfg_next.aware_timeout_ms =
                        dms_pkg::ms_of(cfg_wdata[dms_pkg::SEC_W-1:0]);
                end
                dms_pkg::CFG_STATUS_IVL: begin
                    cfg_next.status_ivl_ms =
                        dms_pkg::ms_of(cfg_wdata[dms_pkg::SEC_W-1:0]);
                end
                dms_pkg::CFG_MAX_UNACKED: begin
                    cfg_next.unacked_limit = (cfg_wdata[dms_pkg::CNT_W-1:0] == '0) ?
                        dms_pkg::CNT_W'(1) : cfg_wdata[dms_pkg::CNT_W-1:0];
                end
                dms_pkg::CFG_DEFAULT_SLEEP: cfg_next.idle_sleep_s = cfg_wdata;
                dms_pkg::CFG_MAX_FORCED:    cfg_next.max_forced_s = cfg_wdata;
                dms_pkg::CFG_LOW_BATT: begin
                    cfg_next.low_batt_mv = cfg_wdata[dms_pkg::MV_W-1:0];
                end
                dms_pkg::CFG_EMERG_DELAY: begin
                    cfg_next.emerg_delay_ms = dms_pkg::TIME_W'(
                        dms_pkg::ms_of(cfg_wdata[dms_pkg::SEC_W-1:0]));
                end
                dms_pkg::CFG_EMERG_SLEEP:   cfg_next.emerg_sleep_s = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.aware_timeout_ms <= dms_pkg::ms_of(dms_pkg::RST_AWARE_TIMEOUT_S);
            cfg_reg.status_ivl_ms    <= dms_pkg::ms_of(dms_pkg::RST_STATUS_IVL_S);
            cfg_reg.emerg_delay_ms   <= dms_pkg::TIME_W'(
                dms_pkg::ms_of(dms_pkg::RST_EMERG_DELAY_S));
            cfg_reg.unacked_limit    <= dms_pkg::RST_MAX_UNACKED;
            cfg_reg.idle_sleep_s     <= dms_pkg::RST_DEFAULT_SLEEP_S;
            cfg_reg.max_forced_s     <= dms_pkg::RST_MAX_FORCED_S;
            cfg_reg.low_batt_mv      <= dms_pkg::RST_LOW_BATT_MV;
            cfg_reg.emerg_sleep_s    <= dms_pkg::RST_EMERG_SLEEP_S;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/dms_core.sv @@
// dms_core: input register, single-pass mode update and result register.
// Depends on dms_pkg; configuration comes from dms_cfg.

module dms_core #(
    parameter logic [dms_pkg::TIME_W-1:0] NO_NET_TIMEOUT_MS = dms_pkg::NO_NET_TIMEOUT_MS_DEF,
    parameter logic [dms_pkg::TIME_W-1:0] NO_NET_SLEEP_S    = dms_pkg::NO_NET_SLEEP_S_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dms_pkg::cfg_t       cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  dms_pkg::in_beat_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dms_pkg::out_beat_t  m_data
);

    localparam int unsigned TW = dms_pkg::TIME_W;
    localparam int unsigned CW = dms_pkg::CNT_W;

    // pipeline registers
    dms_pkg::in_beat_t  in_reg;
    logic               in_valid_reg, in_valid_next;
    dms_pkg::out_beat_t out_reg;
    logic               out_valid_reg, out_valid_next;

    // supervisor state
    logic [1:0]    cur_mode_reg, cur_mode_next;
    logic [TW-1:0] last_act_reg, last_act_next;
    logic [TW-1:0] last_stat_reg, last_stat_next;
    logic [CW-1:0] unacked_reg, unacked_next;
    logic          armed_reg, armed_next;
    logic [TW-1:0] emerg_at_reg, emerg_at_next;
    logic          link_up_reg, link_up_next;
    logic          no_net_reg, no_net_next;

    dms_pkg::out_beat_t res;
    logic               out_free, in_fire, s_take;
    logic               awake;
    logic [TW-1:0]      now, stat_diff, act_diff, sleep_cmd;

    assign out_free = !out_valid_reg || m_ready;
    assign in_fire  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_take   = s_valid && s_ready;
    assign now      = in_reg.now_ms;

    always_comb begin
        cur_mode_next  = cur_mode_reg;
        last_act_next  = last_act_reg;
        last_stat_next = last_stat_reg;
        unacked_next   = unacked_reg;
        armed_next     = armed_reg;
        emerg_at_next  = emerg_at_reg;
        link_up_next   = link_up_reg;
        no_net_next    = no_net_reg;
        res            = '0;
        res.prior_mode = cur_mode_reg;
        awake          = 1'b0;
        stat_diff      = now - last_stat_reg;
        act_diff       = '0;
        sleep_cmd      = '0;

        case (in_reg.req_type)
            dms_pkg::REQ_POLL: begin
                // no-network check uses time since boot
                if (!no_net_reg && cur_mode_reg != dms_pkg::MODE_HIBERNATING &&
                    !link_up_reg && now > NO_NET_TIMEOUT_MS) begin
                    no_net_next        = 1'b1;
                    res.sleep_request  = 1'b1;
                    res.sleep_seconds  = NO_NET_SLEEP_S;
                    res.sleep_reason   = dms_pkg::RSN_NO_NET;
                    res.mode_entered   = 1'b1;
                    res.prior_mode     = cur_mode_next;
                    cur_mode_next      = dms_pkg::MODE_HIBERNATING;
                    last_act_next      = now;
                end

                awake = cur_mode_next == dms_pkg::MODE_AWARE ||
                        cur_mode_next == dms_pkg::MODE_SAMPLING;
                if (awake && (last_stat_reg == '0 ||
                              {1'b0, stat_diff} > cfg.status_ivl_ms)) begin
                    res.status_report = 1'b1;
                    last_stat_next    = now;
                    if (in_reg.battery_mv < cfg.low_batt_mv) begin
                        if (!armed_reg) begin
                            armed_next            = 1'b1;
                            emerg_at_next         = now + cfg.emerg_delay_ms;
                            res.low_battery_alert = 1'b1;
                        end
                    end else begin
                        armed_next = 1'b0;
                    end
                end

                act_diff = now - last_act_next;
                if (armed_next && now >= emerg_at_next) begin
                    res.sleep_request = 1'b1;
                    res.sleep_seconds = cfg.emerg_sleep_s;
                    res.sleep_reason  = dms_pkg::RSN_EMERGENCY;
                    res.mode_entered  = 1'b1;
                    res.prior_mode    = cur_mode_next;
                    cur_mode_next     = dms_pkg::MODE_HIBERNATING;
                    last_act_next     = now;
                end else if (awake && {1'b0, act_diff} > cfg.aware_timeout_ms) begin
                    res.sleep_request = 1'b1;
                    res.sleep_seconds = cfg.idle_sleep_s;
                    res.sleep_reason  = dms_pkg::RSN_INACTIVITY;
                    res.mode_entered  = 1'b1;
                    res.prior_mode    = cur_mode_next;
                    cur_mode_next     = dms_pkg::MODE_HIBERNATING;
                    last_act_next     = now;
                end else if (cur_mode_next == dms_pkg::MODE_SAMPLING &&
                             unacked_reg >= cfg.unacked_limit) begin
                    res.mode_entered = 1'b1;
                    res.prior_mode   = cur_mode_next;
                    cur_mode_next    = dms_pkg::MODE_AWARE;
                    last_act_next    = now;
                    unacked_next     = '0;
                end
            end
            dms_pkg::REQ_ACTIVITY: last_act_next = now;
            dms_pkg::REQ_LINK_DN: begin
                last_act_next = now;
                link_up_next  = 1'b0;
            end
            dms_pkg::REQ_LINK_UP: begin
                last_act_next = now;
                link_up_next  = 1'b1;
            end
            dms_pkg::REQ_AGG_PUB: begin
                last_act_next = now;
                if (cur_mode_reg == dms_pkg::MODE_SAMPLING && unacked_reg != '1) begin
                    unacked_next = unacked_reg + CW'(1);
                end
            end
            dms_pkg::REQ_COMMAND: begin
                last_act_next = now;
                case (in_reg.cmd_code)
                    dms_pkg::CMD_KEEP: unacked_next = '0;
                    dms_pkg::CMD_START: begin
                        res.side_request = dms_pkg::SIDE_SESSION;
                        res.mode_entered = 1'b1;
                        cur_mode_next    = dms_pkg::MODE_SAMPLING;
                        unacked_next     = '0;
                    end
                    dms_pkg::CMD_STOP: begin
                        res.mode_entered = 1'b1;
                        cur_mode_next    = dms_pkg::MODE_AWARE;
                        unacked_next     = '0;
                    end
                    dms_pkg::CMD_GETCONFIG: res.side_request = dms_pkg::SIDE_PUB_CFG;
                    dms_pkg::CMD_HIBERNATE: begin
                        sleep_cmd = (in_reg.cmd_sleep_s == '0) ?
                                    cfg.idle_sleep_s : in_reg.cmd_sleep_s;
                        if (sleep_cmd > cfg.max_forced_s) begin
                            sleep_cmd = cfg.max_forced_s;
                        end
                        res.sleep_request = 1'b1;
                        res.sleep_seconds = sleep_cmd;
                        res.sleep_reason  = dms_pkg::RSN_FORCED;
                        res.mode_entered  = 1'b1;
                        cur_mode_next     = dms_pkg::MODE_HIBERNATING;
                    end
                    dms_pkg::CMD_BATRESET: res.side_request = dms_pkg::SIDE_BAT_RST;
                    dms_pkg::CMD_FACTORY:  res.side_request = dms_pkg::SIDE_FACTORY;
                    default: ;   // nudge and unknown codes: activity only
                endcase
            end
            default: ;   // undefined request types leave everything alone
        endcase

        res.mode = cur_mode_next;
        if (!res.mode_entered) begin
            res.prior_mode = cur_mode_next;
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (in_fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (in_fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_mode_reg  <= dms_pkg::MODE_AWARE;
            last_act_reg  <= '0;
            last_stat_reg <= '0;
            unacked_reg   <= '0;
            armed_reg     <= 1'b0;
            emerg_at_reg  <= '0;
            link_up_reg   <= 1'b0;
            no_net_reg    <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (in_fire) begin
                cur_mode_reg  <= cur_mode_next;
                last_act_reg  <= last_act_next;
                last_stat_reg <= last_stat_next;
                unacked_reg   <= unacked_next;
                armed_reg     <= armed_next;
                emerg_at_reg  <= emerg_at_next;
                link_up_reg   <= link_up_next;
                no_net_reg    <= no_net_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_reg <= s_data;
        end
        if (in_fire) begin
            out_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

@@ rtl/dms_checker.sv @@
// dms_checker: port-level assertions for device_mode_supervisor_top, with bind.
// Depends on dms_pkg and device_mode_supervisor_top.

module dms_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input dms_pkg::in_beat_t              s_data,
    input logic                           m_valid,
    input logic                           m_ready,
    input dms_pkg::out_beat_t             m_data
);

    // waiting request beat holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("request beat changed while waiting");

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // a sleep request always comes with an entry into hibernating
    a_sleep_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.sleep_request |->
            m_data.mode == dms_pkg::MODE_HIBERNATING && m_data.mode_entered)
        else $error("sleep request without hibernate entry");

    // no request: seconds and reason are zero
    a_sleep_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.sleep_request |->
            m_data.sleep_seconds == '0 && m_data.sleep_reason == dms_pkg::RSN_INACTIVITY)
        else $error("sleep fields set without request");

    // without an entry the prior mode is the mode
    a_prior: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.mode_entered |-> m_data.prior_mode == m_data.mode)
        else $error("prior mode differs without entry");

endmodule

bind device_mode_supervisor_top dms_checker u_dms_checker (.*);

@@ sim/device_mode_supervisor_top_tb.sv @@
// Self-checking testbench for device_mode_supervisor_top: random and directed request beats,
// results checked against a behavioral mode-supervisor predictor.
// Depends on rtl/dms_pkg.sv and the device_mode_supervisor_top RTL.
`timescale 1ns / 100ps

module device_mode_supervisor_top_tb;

    import dms_pkg::*;

    localparam int unsigned N_REGS       = 8;
    localparam int unsigned PHASE_BEATS  = 100;
    localparam int unsigned N_PHASES     = 6;
    localparam int unsigned DRAIN_CYCLES = 5;
    localparam longint     SIM_LIMIT_NS = 5_000_000;

    // largest second counts whose ms value still fits 32 bits (23-bit fields)
    localparam logic [31:0] SEC23_MAX = 32'd4294967;
    localparam logic [31:0] U16_MAX   = 32'd65535;
    localparam logic [31:0] U32_MAX   = 32'hFFFF_FFFF;

    // request types and command codes the package leaves unnamed
    localparam logic [2:0] REQ_RSVD6         = 3'd6;
    localparam logic [2:0] REQ_RSVD7         = 3'd7;
    localparam logic [3:0] CMD_FIRST_UNKNOWN = 4'd8;
    localparam logic [3:0] CMD_LAST_UNKNOWN  = 4'd15;

    // ------------------------------------------------------------------
    // DUT ports; every input is known from time zero
    // ------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_beat_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_beat_t             m_data;

    device_mode_supervisor_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Stimulus / scoreboard storage
    // ------------------------------------------------------------------
    in_beat_t    pending_beats[$];      // request beats not yet driven
    out_beat_t   expected_results[$];   // predicted result beats, oldest first
    logic [31:0] reg_val [N_REGS];      // register image for the next setting

    int unsigned tx_idle_pct = 35;
    int unsigned rx_idle_pct = 73;
    bit          beat_taken  = 1'b0;    // request beat accepted at the last rising edge
    logic [31:0] now_cur     = '0;      // running timestamp for generated beats

    int unsigned err_cnt    = 0;
    int unsigned n_checked  = 0;
    int unsigned n_settings = 0;
    int unsigned n_status   = 0;
    int unsigned n_alert    = 0;
    int unsigned n_entries  = 0;
    int unsigned n_sleep [4] = '{default: 0};

    // ------------------------------------------------------------------
    // Predictor: register shadow and supervisor state
    // ------------------------------------------------------------------
    logic [SEC_W-1:0]  cfg_aware_s     = RST_AWARE_TIMEOUT_S;
    logic [SEC_W-1:0]  cfg_status_s    = RST_STATUS_IVL_S;
    logic [CNT_W-1:0]  cfg_max_unacked = RST_MAX_UNACKED;
    logic [TIME_W-1:0] cfg_def_sleep   = RST_DEFAULT_SLEEP_S;
    logic [TIME_W-1:0] cfg_max_forced  = RST_MAX_FORCED_S;
    logic [MV_W-1:0]   cfg_low_mv      = RST_LOW_BATT_MV;
    logic [SEC_W-1:0]  cfg_emerg_delay = RST_EMERG_DELAY_S;
    logic [TIME_W-1:0] cfg_emerg_sleep = RST_EMERG_SLEEP_S;

    logic [1:0]        sup_mode        = MODE_AWARE;
    logic [TIME_W-1:0] sup_last_act    = '0;
    logic [TIME_W-1:0] sup_last_status = '0;   // zero: no report yet
    logic [CNT_W-1:0]  sup_unacked     = '0;
    logic              sup_armed       = 1'b0;
    logic [TIME_W-1:0] sup_emerg_at    = '0;
    logic              sup_link_up     = 1'b0;
    logic              sup_no_net_done = 1'b0;
    out_beat_t         sup_res;

    function automatic void set_shadow_reg(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [31:0] val);
        case (idx)
            CFG_AWARE_TIMEOUT: cfg_aware_s     = val[SEC_W-1:0];
            CFG_STATUS_IVL:    cfg_status_s    = val[SEC_W-1:0];
            CFG_MAX_UNACKED:   cfg_max_unacked = val[CNT_W-1:0];
            CFG_DEFAULT_SLEEP: cfg_def_sleep   = val;
            CFG_MAX_FORCED:    cfg_max_forced  = val;
            CFG_LOW_BATT:      cfg_low_mv      = val[MV_W-1:0];
            CFG_EMERG_DELAY:   cfg_emerg_delay = val[SEC_W-1:0];
            CFG_EMERG_SLEEP:   cfg_emerg_sleep = val;
            default: ;
        endcase
    endfunction

    // Elapsed check: the ms gap wraps at 32 bits, the seconds limit is scaled
    // exactly, so big register values simply never expire.
    function automatic bit has_elapsed(input logic [31:0] now, input logic [31:0] since,
                                       input logic [SEC_W-1:0] secs);
        logic [31:0] gap;
        gap = now - since;
        return {32'd0, gap} > ({41'd0, secs} * 64'd1000);
    endfunction

    // Every entry restamps activity; waking modes drop the unacked count.
    function automatic void enter_mode(input logic [1:0] m, input logic [31:0] now);
        sup_res.mode_entered = 1'b1;
        sup_res.prior_mode   = sup_mode;
        sup_mode             = m;
        sup_last_act         = now;
        if (m != MODE_HIBERNATING) begin
            sup_unacked = '0;
        end
    endfunction

    // A later sleep in the same poll overrides the earlier one's report.
    function automatic void request_sleep(input logic [31:0] secs, input logic [1:0] reason,
                                          input logic [31:0] now);
        sup_res.sleep_request = 1'b1;
        sup_res.sleep_seconds = secs;
        sup_res.sleep_reason  = reason;
        enter_mode(MODE_HIBERNATING, now);
    endfunction

    function automatic void poll_update(input logic [31:0] now, input logic [MV_W-1:0] mv);
        logic [CNT_W-1:0] lim;
        // no-network check: compares raw time since boot, fires once per run
        if (!sup_no_net_done && sup_mode != MODE_HIBERNATING && !sup_link_up &&
            now > NO_NET_TIMEOUT_MS_DEF) begin
            sup_no_net_done = 1'b1;
            request_sleep(NO_NET_SLEEP_S_DEF, RSN_NO_NET, now);
        end
        if (sup_mode != MODE_HIBERNATING &&
            (sup_last_status == '0 || has_elapsed(now, sup_last_status, cfg_status_s))) begin
            sup_res.status_report = 1'b1;
            sup_last_status       = now;
            if (mv < cfg_low_mv) begin
                if (!sup_armed) begin
                    sup_armed                 = 1'b1;
                    sup_emerg_at              = now + ({9'd0, cfg_emerg_delay} * MS_PER_S);
                    sup_res.low_battery_alert = 1'b1;
                end
            end else begin
                sup_armed = 1'b0;
            end
        end
        // armed deadline is a plain unsigned compare, stays armed afterwards
        if (sup_armed && now >= sup_emerg_at) begin
            request_sleep(cfg_emerg_sleep, RSN_EMERGENCY, now);
        end else if (sup_mode != MODE_HIBERNATING &&
                     has_elapsed(now, sup_last_act, cfg_aware_s)) begin
            request_sleep(cfg_def_sleep, RSN_INACTIVITY, now);
        end else if (sup_mode == MODE_SAMPLING) begin
            lim = (cfg_max_unacked == '0) ? CNT_W'(1) : cfg_max_unacked;
            if (sup_unacked >= lim) begin
                enter_mode(MODE_AWARE, now);
            end
        end
    endfunction

    function automatic void run_command(input logic [3:0] code, input logic [31:0] req_s,
                                        input logic [31:0] now);
        logic [31:0] secs;
        case (code)
            CMD_KEEP:      sup_unacked = '0;
            CMD_START: begin
                sup_res.side_request = SIDE_SESSION;
                enter_mode(MODE_SAMPLING, now);
            end
            CMD_STOP:      enter_mode(MODE_AWARE, now);
            CMD_GETCONFIG: sup_res.side_request = SIDE_PUB_CFG;
            CMD_HIBERNATE: begin
                secs = (req_s == '0) ? cfg_def_sleep : req_s;
                if (secs > cfg_max_forced) begin
                    secs = cfg_max_forced;
                end
                request_sleep(secs, RSN_FORCED, now);
            end
            CMD_BATRESET:  sup_res.side_request = SIDE_BAT_RST;
            CMD_FACTORY:   sup_res.side_request = SIDE_FACTORY;
            default: ;     // nudge and unknown codes only refresh activity
        endcase
    endfunction

    // Advance the supervisor by one request beat and return its result beat.
    function automatic out_beat_t predict_result(input in_beat_t b);
        sup_res            = '0;
        sup_res.prior_mode = sup_mode;
        case (b.req_type)
            REQ_POLL:     poll_update(b.now_ms, b.battery_mv);
            REQ_ACTIVITY: sup_last_act = b.now_ms;
            REQ_LINK_DN: begin
                sup_last_act = b.now_ms;
                sup_link_up  = 1'b0;
            end
            REQ_LINK_UP: begin
                sup_last_act = b.now_ms;
                sup_link_up  = 1'b1;
            end
            REQ_AGG_PUB: begin
                sup_last_act = b.now_ms;
                if (sup_mode == MODE_SAMPLING && sup_unacked != '1) begin
                    sup_unacked = sup_unacked + 1'b1;
                end
            end
            REQ_COMMAND: begin
                sup_last_act = b.now_ms;
                run_command(b.cmd_code, b.cmd_sleep_s, b.now_ms);
            end
            default: ;    // reserved types leave everything alone
        endcase
        if (!sup_res.mode_entered) begin
            sup_res.prior_mode = sup_mode;
        end
        sup_res.mode = sup_mode;
        return sup_res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    function automatic void queue_beat(input logic [2:0] req, input logic [31:0] now,
                                       input logic [3:0] code, input logic [31:0] secs,
                                       input logic [MV_W-1:0] mv);
        in_beat_t b;
        b.req_type    = req;
        b.now_ms      = now;
        b.cmd_code    = code;
        b.cmd_sleep_s = secs;
        b.battery_mv  = mv;
        pending_beats.push_back(b);
    endfunction

    // Battery samples cluster around the threshold so arming and disarming
    // both happen often; a fifth are anywhere in range.
    function automatic logic [MV_W-1:0] pick_battery();
        int mv;
        if ($urandom_range(99) < 20) begin
            return MV_W'($urandom);
        end
        mv = int'(cfg_low_mv) + int'($urandom_range(400)) - 200;
        if (mv < 0) begin
            mv = 0;
        end else if (mv > int'(U16_MAX)) begin
            mv = int'(U16_MAX);
        end
        return MV_W'(mv);
    endfunction

    function automatic logic [3:0] pick_command();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 25)      return CMD_START;
        else if (r < 40) return CMD_STOP;
        else if (r < 50) return CMD_KEEP;
        else if (r < 62) return CMD_HIBERNATE;
        else if (r < 68) return CMD_GETCONFIG;
        else if (r < 74) return CMD_BATRESET;
        else if (r < 78) return CMD_FACTORY;
        else if (r < 88) return CMD_NUDGE;
        else             return 4'($urandom_range(CMD_LAST_UNKNOWN, CMD_FIRST_UNKNOWN));
    endfunction

    function automatic in_beat_t random_beat();
        in_beat_t    b;
        int unsigned r;
        // time mostly creeps forward; the odd long gap expires timers and the
        // odd jump lands anywhere, so the ms differences wrap now and then
        r = $urandom_range(99);
        if (r < 45)      now_cur = now_cur + $urandom_range(500);
        else if (r < 75) now_cur = now_cur + $urandom_range(5000);
        else if (r < 92) now_cur = now_cur + $urandom_range(100000);
        else if (r < 98) now_cur = now_cur + $urandom_range(32'h00FF_FFFF);
        else             now_cur = $urandom;
        b.now_ms      = now_cur;
        b.cmd_code    = 4'($urandom);      // don't-care fields carry noise
        b.cmd_sleep_s = $urandom;
        b.battery_mv  = MV_W'($urandom);
        r = $urandom_range(99);
        if (r < 40) begin
            b.req_type   = REQ_POLL;
            b.battery_mv = pick_battery();
        end else if (r < 50) begin
            b.req_type = REQ_ACTIVITY;
        end else if (r < 55) begin
            b.req_type = REQ_LINK_DN;
        end else if (r < 63) begin
            b.req_type = REQ_LINK_UP;
        end else if (r < 78) begin
            b.req_type = REQ_AGG_PUB;
        end else if (r < 96) begin
            b.req_type = REQ_COMMAND;
            b.cmd_code = pick_command();
            if (b.cmd_code == CMD_HIBERNATE) begin
                r = $urandom_range(99);
                if (r < 30)      b.cmd_sleep_s = '0;
                else if (r < 70) b.cmd_sleep_s = $urandom_range(200000);
            end
        end else begin
            b.req_type = ($urandom_range(1) != 0) ? REQ_RSVD7 : REQ_RSVD6;
        end
        return b;
    endfunction

    function automatic void typical_setting();
        reg_val[CFG_AWARE_TIMEOUT] = $urandom_range(600, 1);
        reg_val[CFG_STATUS_IVL]    = $urandom_range(120, 1);
        reg_val[CFG_MAX_UNACKED]   = $urandom_range(8, 1);
        reg_val[CFG_DEFAULT_SLEEP] = $urandom;
        reg_val[CFG_MAX_FORCED]    = ($urandom_range(1) != 0) ? $urandom
                                                              : $urandom_range(200000);
        reg_val[CFG_LOW_BATT]      = $urandom_range(3600, 3000);
        reg_val[CFG_EMERG_DELAY]   = $urandom_range(120);
        reg_val[CFG_EMERG_SLEEP]   = $urandom;
    endfunction

    // Register settings per random phase: typical, fast timers, all at
    // maximum, all zero, then typical again.
    function automatic void pick_setting(input int unsigned ph);
        case (ph)
            1: begin
                reg_val[CFG_AWARE_TIMEOUT] = 5;
                reg_val[CFG_STATUS_IVL]    = 2;
                reg_val[CFG_MAX_UNACKED]   = 0;     // acts as a limit of one
                reg_val[CFG_DEFAULT_SLEEP] = $urandom;
                reg_val[CFG_MAX_FORCED]    = 1000;
                reg_val[CFG_LOW_BATT]      = 32'(RST_LOW_BATT_MV);
                reg_val[CFG_EMERG_DELAY]   = 3;
                reg_val[CFG_EMERG_SLEEP]   = $urandom;
            end
            2: begin
                // max delay makes the deadline wrap to just behind now
                reg_val[CFG_AWARE_TIMEOUT] = SEC23_MAX;
                reg_val[CFG_STATUS_IVL]    = SEC23_MAX;
                reg_val[CFG_MAX_UNACKED]   = U16_MAX;
                reg_val[CFG_DEFAULT_SLEEP] = U32_MAX;
                reg_val[CFG_MAX_FORCED]    = U32_MAX;
                reg_val[CFG_LOW_BATT]      = U16_MAX;
                reg_val[CFG_EMERG_DELAY]   = SEC23_MAX;
                reg_val[CFG_EMERG_SLEEP]   = U32_MAX;
            end
            3: begin
                for (int i = 0; i < N_REGS; i++) begin
                    reg_val[CFG_IDX_W'(i)] = '0;
                end
            end
            default: typical_setting();
        endcase
    endfunction

    task automatic write_regs();
        for (int i = 0; i < N_REGS; i++) begin
            @(negedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_addr  <= CFG_IDX_W'(i);
            cfg_wdata <= reg_val[CFG_IDX_W'(i)];
            set_shadow_reg(CFG_IDX_W'(i), reg_val[CFG_IDX_W'(i)]);
        end
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // Block until every queued beat went in and every result came back.
    task automatic wait_drained();
        while (pending_beats.size() != 0 || s_valid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: changes on the falling edge; valid holds until the beat is taken
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || beat_taken) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pending_beats.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure
    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= rx_idle_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: checks result beats first, then predicts for the request beat
    // taken at the same edge (its result can only show up later)
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_monitor
        out_beat_t want;
        if (!aresetn) begin
            beat_taken <= 1'b0;
        end else begin
            beat_taken <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    err_cnt++;
                    $display("%0t: result beat with nothing expected, expected none, actual %p",
                             $time, m_data);
                end else begin
                    want = expected_results.pop_front();
                    n_checked++;
                    check_field("mode", 32'(want.mode), 32'(m_data.mode));
                    check_field("mode_entered", 32'(want.mode_entered),
                                32'(m_data.mode_entered));
                    check_field("prior_mode", 32'(want.prior_mode), 32'(m_data.prior_mode));
                    check_field("status_report", 32'(want.status_report),
                                32'(m_data.status_report));
                    check_field("low_battery_alert", 32'(want.low_battery_alert),
                                32'(m_data.low_battery_alert));
                    check_field("sleep_request", 32'(want.sleep_request),
                                32'(m_data.sleep_request));
                    check_field("sleep_seconds", want.sleep_seconds, m_data.sleep_seconds);
                    check_field("sleep_reason", 32'(want.sleep_reason),
                                32'(m_data.sleep_reason));
                    check_field("side_request", 32'(want.side_request),
                                32'(m_data.side_request));
                    if (want.sleep_request) n_sleep[want.sleep_reason]++;
                    if (want.status_report) n_status++;
                    if (want.low_battery_alert) n_alert++;
                    if (want.mode_entered) n_entries++;
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_result(s_data));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed walk at reset settings. Link stays down at first, so the
        // no-network case is reachable later on.
        // Status at time zero: the stamp stays zero, so a second poll reports again.
        queue_beat(REQ_POLL,    32'd0,      CMD_NUDGE, $urandom, 16'd4000);
        queue_beat(REQ_POLL,    32'd0,      CMD_NUDGE, $urandom, 16'd4000);
        queue_beat(REQ_LINK_UP, 32'd10,     CMD_NUDGE, $urandom, 16'($urandom));
        // start a session, reach the unacked limit, poll falls back to aware
        queue_beat(REQ_COMMAND, 32'd20,     CMD_START, $urandom, 16'($urandom));
        queue_beat(REQ_AGG_PUB, 32'd30,     CMD_NUDGE, $urandom, 16'($urandom));
        queue_beat(REQ_AGG_PUB, 32'd40,     CMD_NUDGE, $urandom, 16'($urandom));
        queue_beat(REQ_AGG_PUB, 32'd50,     CMD_NUDGE, $urandom, 16'($urandom));
        queue_beat(REQ_POLL,    32'd1000,   CMD_NUDGE, $urandom, 16'd4000);
        // remaining commands, an unknown code included
        queue_beat(REQ_COMMAND, 32'd1100,   CMD_KEEP,         $urandom, 16'($urandom));
        queue_beat(REQ_COMMAND, 32'd1200,   CMD_GETCONFIG,    $urandom, 16'($urandom));
        queue_beat(REQ_COMMAND, 32'd1300,   CMD_BATRESET,     $urandom, 16'($urandom));
        queue_beat(REQ_COMMAND, 32'd1400,   CMD_FACTORY,      $urandom, 16'($urandom));
        queue_beat(REQ_COMMAND, 32'd1500,   CMD_NUDGE,        $urandom, 16'($urandom));
        queue_beat(REQ_COMMAND, 32'd1600,   CMD_LAST_UNKNOWN, $urandom, 16'($urandom));
        // forced sleep: unspecified seconds, then a request above the clamp
        queue_beat(REQ_COMMAND, 32'd2000,   CMD_HIBERNATE, 32'd0, 16'($urandom));
        queue_beat(REQ_COMMAND, 32'd2100,   CMD_STOP,      $urandom, 16'($urandom));
        queue_beat(REQ_COMMAND, 32'd2200,   CMD_HIBERNATE, U32_MAX,  16'($urandom));
        queue_beat(REQ_COMMAND, 32'd3000,   CMD_START,     $urandom, 16'($urandom));
        // low battery arms at a status report; deadline hit, then hit again
        // while hibernating since the arm is sticky
        queue_beat(REQ_POLL,    32'd62000,  CMD_NUDGE, $urandom, 16'd0);
        queue_beat(REQ_POLL,    32'd122000, CMD_NUDGE, $urandom, 16'd0);
        queue_beat(REQ_POLL,    32'd123000, CMD_NUDGE, $urandom, 16'd0);
        queue_beat(REQ_RSVD6,   32'd123500, CMD_NUDGE, $urandom, 16'($urandom));
        // wake, clear the arm with a good sample, then lose the link
        queue_beat(REQ_COMMAND, 32'd125000, CMD_STOP,  $urandom, 16'($urandom));
        queue_beat(REQ_POLL,    32'd125500, CMD_NUDGE, $urandom, 16'hFFFF);
        queue_beat(REQ_LINK_DN, 32'd126000, CMD_NUDGE, $urandom, 16'($urandom));
        queue_beat(REQ_POLL,    32'd126500, CMD_NUDGE, $urandom, 16'hFFFF);
        // inactivity one ms past the timeout
        queue_beat(REQ_COMMAND, 32'd127000, CMD_STOP,  $urandom, 16'($urandom));
        queue_beat(REQ_POLL,    32'd427001, CMD_NUDGE, $urandom, 16'hFFFF);
        now_cur = 32'd427001;
        wait_drained();

        for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
            if (ph < 2) begin
                tx_idle_pct = 35;
                rx_idle_pct = 73;
            end else if (ph < 4) begin
                tx_idle_pct = 73;
                rx_idle_pct = 35;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            pick_setting(ph);
            write_regs();
            repeat (PHASE_BEATS) pending_beats.push_back(random_beat());
            wait_drained();
        end

        // let any stray result beat surface before judging
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0) begin
            err_cnt++;
            $display("%0t: %0d result beats expected, actual none",
                     $time, expected_results.size());
        end

        $display("Checked %0d result beats over %0d register settings, %0d mode entries",
                 n_checked, n_settings, n_entries);
        $display("Sleeps inactivity/forced/emergency/no-net %0d/%0d/%0d/%0d, %0d status, %0d alerts",
                 n_sleep[RSN_INACTIVITY], n_sleep[RSN_FORCED], n_sleep[RSN_EMERGENCY],
                 n_sleep[RSN_NO_NET], n_status, n_alert);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(SIM_LIMIT_NS);
        $display("Timeout with %0d result beats still expected", expected_results.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
